FILE: rtl/midi_tick_to_time_converter_assert.svh
// Assertion macros used by the tempo map RTL
`ifndef MIDI_TICK_TO_TIME_CONVERTER_ASSERT_SVH
`define MIDI_TICK_TO_TIME_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mtt_pkg.sv
package mtt_pkg;

  localparam int TICK_W   = 32;
  localparam int TEMPO_W  = 24;
  localparam int TIME_W   = 56;
  localparam int DIV_W    = 16;
  localparam int DIVCNT_W = 6;

  localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO_US = TEMPO_W'(500000);
  localparam logic [DIV_W-1:0]   TPQ_RESET        = DIV_W'(96);
  localparam logic [DIVCNT_W-1:0] DIV_LAST        = DIVCNT_W'(TIME_W - 1);

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_CONVERT = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OUT_ORDER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOOK,
    S_MUL,
    S_DIV,
    S_ACC
  } state_t;

endpackage

FILE: rtl/mtt_ram.sv
module mtt_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/midi_tick_to_time_converter.sv
// Channel  Ports                                           Handshake
// -------  ----------------------------------------------  -----------------------------
// input    in_mode, in_tick, in_tempo_us_per_quarter       start high, busy low
// result   out_time_us, out_status                         out_valid, one-cycle strobe
// config   cfg_wr_data (ticks_per_quarter)                 cfg_wr_en, no wait
//
// For clear, append and the unused mode the result strobes on the
// next cycle and busy stays low, so such transactions may follow back to back.
// A conversion keeps busy high while it walks the entries whose tick lies before the
// query tick; the walk ends past the last entry or at an entry at or after the query
// tick, and each segment passes through the bit-serial divider.
// rst_n is synchronous: it empties the map and sets ticks_per_quarter to 96.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
module midi_tick_to_time_converter
  import mtt_pkg::*;
#(
  parameter int MAX_TEMPO_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [TICK_W-1:0]   in_tick,
  input  logic [TEMPO_W-1:0]  in_tempo_us_per_quarter,
  input  logic                cfg_wr_en,
  input  logic [DIV_W-1:0]    cfg_wr_data,
  output logic                out_valid,
  output logic [TIME_W-1:0]   out_time_us,
  output logic [1:0]          out_status
);

`include "midi_tick_to_time_converter_assert.svh"

  localparam int CNT_W  = $clog2(MAX_TEMPO_ENTRIES + 1);
  localparam int ADDR_W = $clog2(MAX_TEMPO_ENTRIES > 1 ? MAX_TEMPO_ENTRIES : 2);
  localparam int ENTRY_W = TICK_W + TEMPO_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TEMPO_ENTRIES);

  state_t               state_r, state_nxt;
  logic [DIV_W-1:0]     tpq_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TICK_W-1:0]    last_tick_r, last_tick_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [TICK_W-1:0]    qtick_r, qtick_nxt;
  logic [TICK_W-1:0]    prev_r, prev_nxt;
  logic [TEMPO_W-1:0]   tempo_r, tempo_nxt;
  logic [TEMPO_W-1:0]   ntempo_r, ntempo_nxt;
  logic [TICK_W-1:0]    seg_r, seg_nxt;
  logic                 last_r, last_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [TIME_W-1:0]    quo_r, quo_nxt;
  logic [DIV_W:0]       rem_r, rem_nxt;
  logic [DIVCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [TIME_W-1:0]    total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]    out_time_r, out_time_nxt;
  logic [1:0]           out_status_r, out_status_nxt;

  logic                 accept;
  logic                 ram_wr_en;
  logic                 ram_rd_en;
  logic [ENTRY_W-1:0]   ram_rd_data;
  logic [TICK_W-1:0]    look_tick;
  logic [TEMPO_W-1:0]   look_tempo;
  logic                 look_hit;
  logic [DIV_W:0]       rem_sh;
  logic                 rem_ge;
  logic                 append_ok;

  assign accept     = start && !busy;
  assign look_tick  = ram_rd_data[ENTRY_W-1:TEMPO_W];
  assign look_tempo = ram_rd_data[TEMPO_W-1:0];
  assign look_hit   = look_tick < qtick_r;
  assign append_ok  = (count_r != CNT_FULL) && !((count_r != '0) && (in_tick < last_tick_r));

  // Shared divider step: shift in the next dividend bit, compare, subtract
  assign rem_sh = {rem_r[DIV_W-1:0], quo_r[TIME_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_r};

  mtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TEMPO_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data ({in_tick, in_tempo_us_per_quarter}),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_CONVERT)) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = (idx_r < count_r) ? S_LOOK : S_MUL;
      end
      S_LOOK: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV: begin
        if (dcnt_r == DIV_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = last_r ? S_IDLE : S_FETCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    ram_rd_en = (state_r == S_FETCH) && (idx_r < count_r);
    ram_wr_en = (state_r == S_IDLE) && accept && (in_mode == MODE_APPEND) && append_ok;
  end

  // Datapath next values
  always_comb begin
    count_nxt      = count_r;
    last_tick_nxt  = last_tick_r;
    idx_nxt        = idx_r;
    qtick_nxt      = qtick_r;
    prev_nxt       = prev_r;
    tempo_nxt      = tempo_r;
    ntempo_nxt     = ntempo_r;
    seg_nxt        = seg_r;
    last_nxt       = last_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    total_nxt      = total_r;
    out_valid_nxt  = 1'b0;
    out_time_nxt   = out_time_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_time_nxt   = '0;
              out_status_nxt = ST_OK;
            end
            MODE_APPEND: begin
              out_valid_nxt = 1'b1;
              out_time_nxt  = '0;
              if (count_r == CNT_FULL) begin
                out_status_nxt = ST_FULL;
              end else if (!append_ok) begin
                out_status_nxt = ST_OUT_ORDER;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + 1'b1;
                last_tick_nxt  = in_tick;
              end
            end
            MODE_CONVERT: begin
              idx_nxt   = '0;
              qtick_nxt = in_tick;
              prev_nxt  = '0;
              tempo_nxt = DEFAULT_TEMPO_US;
              total_nxt = '0;
              div_nxt   = (tpq_r == '0) ? DIV_W'(1) : tpq_r;
            end
            MODE_NOP: begin
              out_valid_nxt  = 1'b1;
              out_time_nxt   = '0;
              out_status_nxt = ST_OK;
            end
            default: ;
          endcase
        end
      end
      // Past the last entry: close the final segment at the query tick
      S_FETCH: begin
        if (!(idx_r < count_r)) begin
          seg_nxt  = qtick_r - prev_r;
          last_nxt = 1'b1;
        end
      end
      // Entry before the query closes a segment, otherwise finish at the query
      S_LOOK: begin
        seg_nxt    = (look_hit ? look_tick : qtick_r) - prev_r;
        last_nxt   = !look_hit;
        ntempo_nxt = look_tempo;
        if (look_hit) begin
          prev_nxt = look_tick;
        end
      end
      // Segment ticks times tempo in force, then load the divider
      S_MUL: begin
        quo_nxt  = TIME_W'(seg_r) * TIME_W'(tempo_r);
        rem_nxt  = '0;
        dcnt_nxt = '0;
        if (!last_r) begin
          tempo_nxt = ntempo_r;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
        quo_nxt  = {quo_r[TIME_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r + 1'b1;
      end
      // Accumulate the truncated segment and advance
      S_ACC: begin
        total_nxt = total_r + quo_r;
        idx_nxt   = idx_r + 1'b1;
        if (last_r) begin
          out_valid_nxt  = 1'b1;
          out_time_nxt   = total_r + quo_r;
          out_status_nxt = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      tpq_r       <= TPQ_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tpq_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    last_tick_r  <= last_tick_nxt;
    idx_r        <= idx_nxt;
    qtick_r      <= qtick_nxt;
    prev_r       <= prev_nxt;
    tempo_r      <= tempo_nxt;
    ntempo_r     <= ntempo_nxt;
    seg_r        <= seg_nxt;
    last_r       <= last_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    dcnt_r       <= dcnt_nxt;
    total_r      <= total_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_time_us = out_time_r;
  assign out_status  = out_status_r;

  `MTT_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, state_r == S_IDLE,
    "result strobe while sequencer active")
  `MTT_ASSERT_NOW(a_error_zero_time, clk, rst_n, out_valid_r && (out_status_r != ST_OK),
    out_time_r == '0, "error status with nonzero time")
  `MTT_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == S_DIV, div_r != '0,
    "divider running with zero divisor")
  `MTT_ASSERT_NEXT(a_quick_result, clk, rst_n, accept && (in_mode != MODE_CONVERT),
    out_valid_r, "clear or append gave no result")
  `MTT_ASSERT_NEXT(a_append_grows, clk, rst_n, ram_wr_en,
    count_r == $past(count_r) + 1'b1, "append did not grow the map")

endmodule
